// File: design/ftxrg_pkg.sv
// Shared types and constants of the four-tap XOR random generator.
`timescale 1ns / 1ps

package ftxrg_pkg;

  localparam int unsigned WORD_W = 31;
  localparam int unsigned MUL_W  = 15;
  localparam int unsigned PROD_W = WORD_W + MUL_W;

  localparam logic [MUL_W-1:0]  LEHMER_MUL = 15'd16807;
  localparam logic [WORD_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;

  // Lags behind the new write index
  localparam int unsigned TAP_LAGS [4] = '{471, 1586, 6988, 9689};

  typedef enum logic {
    OP_RESEED = 1'b0,
    OP_DRAW   = 1'b1
  } op_e;

endpackage

// File: design/ftxrg_if.sv
// Channel interfaces: request, result and seed register write.
`timescale 1ns / 1ps

interface ftxrg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [ftxrg_pkg::WORD_W-1:0]  modulus;

  modport source (output valid, output operation, output modulus, input ready);
  modport sink   (input valid, input operation, input modulus, output ready);
endinterface

interface ftxrg_out_if;
  logic                          valid;
  logic                          ready;
  logic [ftxrg_pkg::WORD_W-1:0]  random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

interface ftxrg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ftxrg_pkg::WORD_W-1:0]  seed_value;

  modport source (output valid, output seed_value, input ready);
  modport sink   (input valid, input seed_value, output ready);
endinterface

// File: design/ftxrg_ring_mem.sv
// Ring store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ftxrg_ring_mem #(
  parameter int unsigned RING_DEPTH = 16384
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(RING_DEPTH)-1:0]   waddr_i,
  input  logic [ftxrg_pkg::WORD_W-1:0]    wdata_i,
  input  logic [$clog2(RING_DEPTH)-1:0]   raddr_i,
  output logic [ftxrg_pkg::WORD_W-1:0]    rdata_o
);

  logic [ftxrg_pkg::WORD_W-1:0] mem_q [RING_DEPTH];
  logic [ftxrg_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ftxrg_lehmer.sv
// Two-stage step x -> 16807 * x mod (2^31 - 1).
`timescale 1ns / 1ps

module ftxrg_lehmer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ftxrg_pkg::WORD_W-1:0]  x_i,
  output logic                          valid_o,
  output logic [ftxrg_pkg::WORD_W-1:0]  y_o
);

  localparam int unsigned SumW = ftxrg_pkg::WORD_W + 1;

  logic                            v1_q, v2_q;
  logic [ftxrg_pkg::PROD_W-1:0]    prod_q;
  logic [ftxrg_pkg::WORD_W-1:0]    y_q;
  logic [SumW-1:0]                 sum;
  logic [SumW-1:0]                 modx;
  logic [ftxrg_pkg::WORD_W-1:0]    y_d;

  // 2^31 == 1 mod (2^31 - 1): fold high part onto low, one correction
  always_comb begin
    sum  = SumW'(prod_q[ftxrg_pkg::PROD_W-1:ftxrg_pkg::WORD_W])
         + SumW'(prod_q[ftxrg_pkg::WORD_W-1:0]);
    modx = SumW'(ftxrg_pkg::LEHMER_MOD);
    if (sum >= modx) begin
      y_d = ftxrg_pkg::WORD_W'(sum - modx);
    end else begin
      y_d = sum[ftxrg_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ftxrg_pkg::PROD_W'(ftxrg_pkg::LEHMER_MUL) * ftxrg_pkg::PROD_W'(x_i);
    y_q    <= y_d;
  end

  assign valid_o = v2_q;
  assign y_o     = y_q;

endmodule

// File: design/ftxrg_mod_div.sv
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module ftxrg_mod_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ftxrg_pkg::WORD_W-1:0]  dividend_i,
  input  logic [ftxrg_pkg::WORD_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [ftxrg_pkg::WORD_W-1:0]  rem_o
);

  localparam int unsigned W    = ftxrg_pkg::WORD_W;
  localparam int unsigned CntW = $clog2(W + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q, dvd_q, dvs_q;
  logic [W:0]      rem_sh;
  logic [W:0]      dvs_ext;
  logic [W-1:0]    rem_d;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[W-1]};
    dvs_ext = {1'b0, dvs_q};
    if (rem_sh >= dvs_ext) begin
      rem_d = W'(rem_sh - dvs_ext);
    end else begin
      rem_d = rem_sh[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: design/four_tap_xor_random_generator.sv
// Top level: four-tap lagged XOR random generator with its sequencer.
`timescale 1ns / 1ps

// Four-tap lagged XOR generator. A ring of RING_DEPTH 31-bit words lives in a
// single-port-read, single-port-write RAM with registered read data. After
// reset a clearing pass writes zero to every word, and no request word is
// taken until it ends; seed writes are taken throughout. A reseed request
// refills the ring with the Lehmer sequence (x * 16807 mod 2^31-1) starting
// from the seed register, each word made from the one before by the two-stage
// multiply/fold unit; it holds the block until the ring is full and returns no
// result. A draw request bumps the write index, reads the four lagged words one
// per cycle through the single read port, XORs them and writes the new word
// back. With a nonzero modulus the word then goes through a bit-serial
// remainder unit (31 iterations). Requests are handled one at a time; the
// result sits in an output register, so the next request is taken while a
// result waits.
module four_tap_xor_random_generator #(
  parameter int unsigned RING_DEPTH = 16384
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ftxrg_cfg_if.sink         cfg_i,
  ftxrg_in_if.sink          in_i,
  ftxrg_out_if.source       out_o
);

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned W    = ftxrg_pkg::WORD_W;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SEED   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_WRITE  = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // control
  logic [IdxW-1:0] clr_cnt_q, clr_cnt_d;
  logic [IdxW-1:0] fill_cnt_q, fill_cnt_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [1:0]      tap_q, tap_d;
  logic            rd_vld_q, rd_vld_d;
  logic            out_valid_q;
  logic [W-1:0]    seed_q;

  // payload
  logic [IdxW-1:0] draw_idx_q, draw_idx_d;
  logic [W-1:0]    modulus_q, modulus_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    res_q, res_d;
  logic [W-1:0]    out_data_q;

  // ring RAM
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [W-1:0]    mem_wdata, mem_rdata;

  // Lehmer unit and remainder unit
  logic            lm_start, lm_valid;
  logic [W-1:0]    lm_x, lm_y;
  logic            div_start, div_done;
  logic [W-1:0]    div_rem;

  logic            in_acc, out_free, out_load;
  logic [W-1:0]    word;

  ftxrg_ring_mem #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ftxrg_lehmer u_lehmer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lm_start),
    .x_i     (lm_x),
    .valid_o (lm_valid),
    .y_o     (lm_y)
  );

  ftxrg_mod_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (res_d),
    .divisor_i  (modulus_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;
  // last lagged word lands straight from the RAM read register
  assign word        = acc_q ^ mem_rdata;
  assign rd_vld_d    = (state_q == S_READ);

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    fill_cnt_d = fill_cnt_q;
    wr_idx_d   = wr_idx_q;
    tap_d      = tap_q;
    draw_idx_d = draw_idx_q;
    modulus_d  = modulus_q;
    acc_d      = acc_q;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt_q;
    mem_wdata  = '0;
    mem_raddr  = draw_idx_q - IdxW'(ftxrg_pkg::TAP_LAGS[tap_q]);
    lm_start   = 1'b0;
    lm_x       = lm_y;
    div_start  = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IdxW'(RING_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.operation == ftxrg_pkg::OP_DRAW) begin
            draw_idx_d = wr_idx_q + 1'b1;
            modulus_d  = in_i.modulus;
            tap_d      = '0;
            acc_d      = '0;
            state_d    = S_READ;
          end else begin
            lm_start   = 1'b1;
            lm_x       = seed_q;
            fill_cnt_d = '0;
            state_d    = S_SEED;
          end
        end
      end
      S_SEED: begin
        if (lm_valid) begin
          mem_we    = 1'b1;
          mem_waddr = fill_cnt_q;
          mem_wdata = lm_y;
          if (fill_cnt_q == IdxW'(RING_DEPTH - 1)) begin
            state_d = S_IDLE;
          end else begin
            lm_start   = 1'b1;
            fill_cnt_d = fill_cnt_q + 1'b1;
          end
        end
      end
      S_READ: begin
        tap_d = tap_q + 1'b1;
        if (rd_vld_q) begin
          acc_d = word;
        end
        if (&tap_q) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = draw_idx_q;
        mem_wdata = word;
        wr_idx_d  = draw_idx_q;
        res_d     = word;
        if (modulus_q != '0) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d   = S_RESULT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = div_rem;
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      fill_cnt_q  <= '0;
      wr_idx_q    <= '0;
      tap_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      seed_q      <= W'(1);
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      fill_cnt_q <= fill_cnt_d;
      wr_idx_q   <= wr_idx_d;
      tap_q      <= tap_d;
      rd_vld_q   <= rd_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        seed_q <= cfg_i.seed_value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    draw_idx_q <= draw_idx_d;
    modulus_q  <= modulus_d;
    acc_q      <= acc_d;
    res_q      <= res_d;
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.random_value = out_data_q;

  // a result word only appears after the result state
  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESULT))
    else $error("result word raised outside result state");

  // write index only moves on the draw write-back
  a_index_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(wr_idx_q) |-> $past(state_q == S_WRITE))
    else $error("write index moved outside draw write-back");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("remainder finished outside divide state");

  a_lehmer_in_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lm_valid |-> (state_q == S_SEED))
    else $error("Lehmer word produced outside reseed");

endmodule

// File: sim/ftxrg_checker.sv
// Checker: watches seed writes, requests and results, predicts each drawn word and compares.
`timescale 1ns / 1ps

module ftxrg_checker #(
  parameter int unsigned RING_DEPTH = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ftxrg_cfg_if        cfg_mon_i,
  ftxrg_in_if         req_mon_i,
  ftxrg_out_if        res_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned WORD_W        = ftxrg_pkg::WORD_W;
  localparam int unsigned IDX_W         = $clog2(RING_DEPTH);
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned SEED_AT_RESET = 1;
  localparam logic [63:0] MINSTD_MUL    = 64'd16807;
  localparam logic [63:0] MINSTD_MOD    = 64'd2147483647;
  localparam int unsigned NUM_TAPS      = 4;
  localparam int unsigned DRAW_LAGS [NUM_TAPS] = '{471, 1586, 6988, 9689};

  logic [WORD_W-1:0] ring_model [RING_DEPTH];
  logic [IDX_W-1:0]  draw_idx;
  logic [WORD_W-1:0] seed_reg;
  logic [WORD_W-1:0] expected_words [$];
  int unsigned       fail_total;

  function automatic logic [WORD_W-1:0] minstd_next(input logic [WORD_W-1:0] x);
    logic [63:0] prod;
    prod = ({33'd0, x} * MINSTD_MUL) % MINSTD_MOD;
    return prod[WORD_W-1:0];
  endfunction

  function automatic void refill_ring();
    ring_model[0] = minstd_next(seed_reg);
    for (int unsigned i = 1; i < RING_DEPTH; i++) begin
      ring_model[i] = minstd_next(ring_model[i-1]);
    end
  endfunction

  // Bump the index, XOR the four lagged words, store and return the new word
  function automatic logic [WORD_W-1:0] draw_lagged_xor();
    logic [IDX_W-1:0]  next_idx;
    logic [IDX_W-1:0]  tap;
    logic [WORD_W-1:0] word;
    next_idx = draw_idx + 1'b1;
    word     = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      tap  = next_idx - IDX_W'(DRAW_LAGS[k]);
      word = word ^ ring_model[tap];
    end
    ring_model[next_idx] = word;
    draw_idx = next_idx;
    return word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [WORD_W-1:0] want;
    if (!rst_ni) begin
      foreach (ring_model[i]) ring_model[i] = '0;
      draw_idx = '0;
      seed_reg = WORD_W'(SEED_AT_RESET);
      expected_words.delete();
      fail_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        seed_reg = cfg_mon_i.seed_value;
      end
      // results first: a word leaving now belongs to an earlier request
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (expected_words.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT) begin
            $display("[%0t] unexpected random_value %0d", $realtime, res_mon_i.random_value);
          end
        end else begin
          want = expected_words.pop_front();
          if (res_mon_i.random_value !== want) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT) begin
              $display("[%0t] random_value mismatch: expected %0d got %0d",
                       $realtime, want, res_mon_i.random_value);
            end
          end
        end
      end
      if (req_mon_i.valid && req_mon_i.ready) begin
        if (req_mon_i.operation == ftxrg_pkg::OP_DRAW) begin
          want = draw_lagged_xor();
          if (req_mon_i.modulus != '0) want = want % req_mon_i.modulus;
          expected_words.push_back(want);
        end else begin
          refill_ring();
        end
      end
      fail_count_o <= fail_total;
      pending_o    <= expected_words.size();
    end
  end

endmodule

// File: sim/tb_four_tap_xor_random_generator.sv
// Testbench top: drives requests, seed writes and result back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module tb_four_tap_xor_random_generator;

  localparam int unsigned WORD_W          = ftxrg_pkg::WORD_W;
  localparam int unsigned RING_DEPTH      = 16384;
  localparam int unsigned CLK_HALF_NS     = 5;
  localparam int unsigned RESET_CYCLES    = 3;
  localparam int unsigned MAX_IDLE        = 12;
  localparam int unsigned RANDOM_PHASES   = 4;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  // a reseed gives no word back: let its refill run out before touching the seed
  localparam int unsigned REFILL_CYCLES   = 2 * RING_DEPTH + 64;
  localparam int unsigned TAIL_CYCLES     = 64;
  // Slowest legal run, roughly: the clearing pass, ~13 reseeds, each with a
  // settle as long as its refill, and ~820 draws, each with its gap, remainder
  // unit and stall. Take a healthy multiple of that.
  localparam int unsigned CYCLE_LIMIT     = 8_000_000;
  localparam logic [WORD_W-1:0] WORD_MAX  = '1;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  // current gap ceiling for both sides; 0 gives stretches at full rate
  int unsigned idle_cap    = MAX_IDLE;
  bit          last_reseed = 1'b0;

  ftxrg_cfg_if cfg_bus ();
  ftxrg_in_if  req_bus ();
  ftxrg_out_if res_bus ();

  always #(CLK_HALF_NS) clk = ~clk;

  four_tap_xor_random_generator #(
    .RING_DEPTH (RING_DEPTH)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (req_bus),
    .out_o  (res_bus)
  );

  ftxrg_checker #(
    .RING_DEPTH (RING_DEPTH)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_mon_i    (cfg_bus),
    .req_mon_i    (req_bus),
    .res_mon_i    (res_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Watchdog: a hang or a missing word ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL four_tap_xor_random_generator");
      $finish;
    end
  end

  // Modulus mix: raw words, tiny moduli, single-bit moduli and full-width values.
  function automatic logic [WORD_W-1:0] rand_modulus();
    case ($urandom_range(5, 0))
      0, 1:    return '0;
      2:       return WORD_W'($urandom_range(16, 1));
      3:       return WORD_W'(1) << $urandom_range(WORD_W - 1, 0);
      default: return WORD_W'($urandom());
    endcase
  endfunction

  // One request word. Called at a rising edge; returns at the edge it is taken.
  task automatic send_req(input ftxrg_pkg::op_e op, input logic [WORD_W-1:0] modv);
    int unsigned gap;
    gap = $urandom_range(idle_cap, 0);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.operation <= op;
    req_bus.modulus   <= modv;
    do @(posedge clk); while (!req_bus.ready);
    last_reseed = (op == ftxrg_pkg::OP_RESEED);
  endtask

  // Seed register write; only called once the block is idle.
  task automatic write_seed(input logic [WORD_W-1:0] seed);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.seed_value <= seed;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // Hold off the sender until every predicted word is back. With settle set, also
  // let a trailing reseed run out so a following seed write finds the block idle.
  task automatic drain_results(input bit settle);
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    if (settle) begin
      repeat (last_reseed ? REFILL_CYCLES : TAIL_CYCLES) @(posedge clk);
      last_reseed = 1'b0;
    end
  endtask

  // Result side: random stall before each word, ready held until it is taken.
  initial begin : result_sink
    int unsigned hold;
    res_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      hold = $urandom_range(idle_cap, 0);
      if (hold > 0) begin
        res_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!(res_bus.valid && res_bus.ready));
    end
  end

  initial begin : stimulus
    cfg_bus.valid      = 1'b0;
    cfg_bus.seed_value = '0;
    req_bus.valid      = 1'b0;
    req_bus.operation  = ftxrg_pkg::OP_RESEED;
    req_bus.modulus    = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // Ring still cleared from reset: draws must come back zero. The first one
    // also waits out the clearing pass.
    send_req(ftxrg_pkg::OP_DRAW, '0);
    send_req(ftxrg_pkg::OP_DRAW, WORD_W'(5));
    // reseed from the reset seed, then raw words and the modulus extremes
    send_req(ftxrg_pkg::OP_RESEED, WORD_MAX);
    send_req(ftxrg_pkg::OP_DRAW, '0);
    send_req(ftxrg_pkg::OP_DRAW, '0);
    send_req(ftxrg_pkg::OP_DRAW, '0);
    send_req(ftxrg_pkg::OP_DRAW, WORD_W'(1));
    send_req(ftxrg_pkg::OP_DRAW, WORD_MAX);
    send_req(ftxrg_pkg::OP_DRAW, WORD_W'(1) << (WORD_W - 1));
    send_req(ftxrg_pkg::OP_DRAW, WORD_W'(2));
    send_req(ftxrg_pkg::OP_DRAW, WORD_W'(3));
    drain_results(1'b1);

    // Seed of 2^31-1 folds to zero: whole ring zero, every draw zero.
    write_seed(WORD_MAX);
    send_req(ftxrg_pkg::OP_RESEED, '0);
    send_req(ftxrg_pkg::OP_DRAW, '0);
    send_req(ftxrg_pkg::OP_DRAW, WORD_W'(7));
    drain_results(1'b1);

    // Seed zero behaves the same way.
    write_seed('0);
    send_req(ftxrg_pkg::OP_RESEED, '0);
    send_req(ftxrg_pkg::OP_DRAW, '0);
    drain_results(1'b1);

    // Largest legal seed.
    write_seed(WORD_MAX - 1'b1);
    send_req(ftxrg_pkg::OP_RESEED, '0);
    send_req(ftxrg_pkg::OP_DRAW, '0);
    send_req(ftxrg_pkg::OP_DRAW, WORD_MAX);
    drain_results(1'b1);

    // --- random phases ---
    // Each phase: fresh seed (first one may hit any 31-bit value), a reseed,
    // then mostly draws with the odd reseed. Full gaps or, one time in four, none,
    // redrawn every 40 words; now and then the sender waits for all results.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      idle_cap = MAX_IDLE;
      drain_results(1'b1);
      if (p == 0) write_seed(WORD_W'($urandom()));
      else        write_seed(WORD_W'($urandom_range(32'h7FFF_FFFE, 1)));
      send_req(ftxrg_pkg::OP_RESEED, WORD_W'($urandom()));
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) idle_cap = ($urandom_range(3, 0) == 0) ? 0 : MAX_IDLE;
        if ($urandom_range(59, 0) == 0) drain_results(1'b0);
        if ($urandom_range(159, 0) == 0) begin
          send_req(ftxrg_pkg::OP_RESEED, WORD_W'($urandom()));
        end else begin
          send_req(ftxrg_pkg::OP_DRAW, rand_modulus());
        end
      end
    end

    // --- wind down ---
    idle_cap = MAX_IDLE;
    drain_results(1'b1);
    if (fail_count == 0) begin
      $display("PASS four_tap_xor_random_generator");
    end else begin
      $display("FAIL four_tap_xor_random_generator");
    end
    $finish;
  end

endmodule
